@@ hw/rtl/rwp_pkg.sv @@
package rwp_pkg;

    // field and register widths
    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 4;

    // datapath widths
    localparam int SCALED_W = 12;  // interval / 30
    localparam int SUM_W    = 13;  // p + c
    localparam int PROD_W   = 24;  // p*c and the divisor v
    localparam int X_W      = 13;  // first quotient x
    localparam int PRED_W   = 16;  // predicted interval, never above 65535

    // shared arithmetic unit
    localparam int OPA_W     = 40;
    localparam int OPB_W     = 24;
    localparam int RES_W     = 42;
    localparam int MUL_A_W   = 26;
    localparam int MUL_B_W   = 16;
    localparam int DIV_Q_W   = 20;
    localparam int DIV_CNT_W = 5;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // divide by 30 as multiply by round-up reciprocal and shift
    localparam logic [MUL_B_W-1:0] SCALE_RECIP = 16'd34953;
    localparam int                 SCALE_SHIFT = 20;
    localparam logic [OPB_W-1:0]   SCALE_DIV   = 24'd30;

    // window as 4/5 or 6/7 of the prediction: multiply by round-up constant and shift
    localparam logic [OPA_W-1:0]   WIN_RECIP_FIRST = 40'd419431;
    localparam logic [OPA_W-1:0]   WIN_RECIP_LATER = 40'd449390;
    localparam int                 WIN_SHIFT       = 19;
    localparam logic [FIELD_W-1:0] GUARD_US        = 16'd50;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_WAIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE   = 4'd2;

    localparam logic [FIELD_W-1:0] BOUNCE_WAIT_RST = 16'd200;
    localparam logic [FIELD_W-1:0] MIN_WINDOW_RST  = 16'd1000;
    localparam logic [FIELD_W-1:0] MIN_PULSE_RST   = 16'd70;

    typedef struct packed {
        logic [FIELD_W-1:0] bounce_wait;
        logic [FIELD_W-1:0] min_window;
        logic [FIELD_W-1:0] min_pulse;
    } cfg_t;

    typedef struct packed {
        logic [FIELD_W-1:0] current_interval;
        logic [FIELD_W-1:0] previous_interval;
        logic [FIELD_W-1:0] on_time_command;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] rearm_delay;
        logic [FIELD_W-1:0] drive_time;
        logic               drive_enable;
    } result_t;

    typedef struct packed {
        logic             go;
        logic             op;
        logic [OPA_W-1:0] opa;
        logic [OPB_W-1:0] opb;
    } arith_req_t;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] res;
    } arith_rsp_t;

endpackage

@@ hw/rtl/rwp_ifs.sv @@
interface rwp_item_if;
    logic                        valid;
    logic                        ready;
    logic [rwp_pkg::FIELD_W-1:0] current_interval;
    logic [rwp_pkg::FIELD_W-1:0] previous_interval;
    logic [rwp_pkg::FIELD_W-1:0] on_time_command;

    modport source (output valid, output current_interval, output previous_interval,
                    output on_time_command, input ready);
    modport sink (input valid, input current_interval, input previous_interval,
                  input on_time_command, output ready);
endinterface

interface rwp_result_if;
    logic                        valid;
    logic                        ready;
    logic [rwp_pkg::FIELD_W-1:0] rearm_delay;
    logic [rwp_pkg::FIELD_W-1:0] drive_time;
    logic                        drive_enable;

    modport source (output valid, output rearm_delay, output drive_time,
                    output drive_enable, input ready);
    modport sink (input valid, input rearm_delay, input drive_time,
                  input drive_enable, output ready);
endinterface

interface rwp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rwp_pkg::CFG_IDX_W-1:0] index;
    logic [rwp_pkg::FIELD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/revolution_window_predictor_unit.sv @@
// result path: straight from the item when the prior interval is zero, through the
// scaling and window steps when not speeding up, and through the whole multiply and
// divide sequence when speeding up; every multiply and 20-bit divide runs on the shared arithmetic unit
// the next item is taken once the result is in the output register
// reset: async active low, registers back to 200/1000/70, last window cleared
module revolution_window_predictor_unit
(
    input  logic          clk,
    input  logic          rst_n,
    rwp_item_if.sink      item_in,
    rwp_result_if.source  result_out,
    rwp_cfg_if.sink       cfg
);

    // configuration registers, always writable
    rwp_pkg::cfg_t      cfg_reg, cfg_next;

    // output register decouples the sequencer from the result sink
    logic               out_valid_reg, out_valid_next;
    rwp_pkg::result_t   out_reg, out_next;

    rwp_pkg::item_t     item;
    rwp_pkg::result_t   core_res;
    logic               core_in_ready;
    logic               core_res_valid;
    logic               core_res_ready;

    assign item.current_interval  = item_in.current_interval;
    assign item.previous_interval = item_in.previous_interval;
    assign item.on_time_command   = item_in.on_time_command;

    rwp_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_reg),
        .in_valid  (item_in.valid),
        .in_ready  (core_in_ready),
        .item      (item),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready),
        .res       (core_res)
    );

    assign item_in.ready = core_in_ready;

    // register write decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                rwp_pkg::REG_BOUNCE_WAIT: cfg_next.bounce_wait = cfg.data;
                rwp_pkg::REG_MIN_WINDOW:  cfg_next.min_window  = cfg.data;
                rwp_pkg::REG_MIN_PULSE:   cfg_next.min_pulse   = cfg.data;
                default:                  cfg_next             = cfg_reg;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // slot frees when empty or being drained this cycle
    assign core_res_ready = !out_valid_reg || result_out.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (core_res_valid && core_res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = core_res;
        end
        else if (result_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bounce_wait <= rwp_pkg::BOUNCE_WAIT_RST;
            cfg_reg.min_window  <= rwp_pkg::MIN_WINDOW_RST;
            cfg_reg.min_pulse   <= rwp_pkg::MIN_PULSE_RST;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.rearm_delay  = out_reg.rearm_delay;
    assign result_out.drive_time   = out_reg.drive_time;
    assign result_out.drive_enable = out_reg.drive_enable;

endmodule

@@ hw/rtl/rwp_arith.sv @@
module rwp_arith
(
    input  logic                clk,
    input  logic                rst_n,
    input  rwp_pkg::arith_req_t req,
    output rwp_pkg::arith_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [rwp_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [rwp_pkg::OPB_W-1:0]         rem_reg, rem_next;
    logic [rwp_pkg::DIV_Q_W-1:0]       wq_reg, wq_next;
    logic [rwp_pkg::OPB_W-1:0]         dvs_reg, dvs_next;
    logic [rwp_pkg::RES_W-1:0]         res_reg, res_next;
    logic [rwp_pkg::RES_W-1:0]         mul_prod;
    logic [rwp_pkg::OPB_W+1:0]         trial;
    logic                              ge;

    assign mul_prod = {{(rwp_pkg::RES_W-rwp_pkg::MUL_A_W){1'b0}}, req.opa[rwp_pkg::MUL_A_W-1:0]}
                    * {{(rwp_pkg::RES_W-rwp_pkg::MUL_B_W){1'b0}}, req.opb[rwp_pkg::MUL_B_W-1:0]};

    // one restoring step: shift next dividend bit into the remainder
    assign trial = {1'b0, rem_reg, wq_reg[rwp_pkg::DIV_Q_W-1]} - {2'b00, dvs_reg};
    assign ge    = ~trial[rwp_pkg::OPB_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        wq_next   = wq_reg;
        dvs_next  = dvs_reg;
        res_next  = res_reg;
        if (busy_reg)
        begin
            rem_next = ge ? trial[rwp_pkg::OPB_W-1:0]
                          : {rem_reg[rwp_pkg::OPB_W-2:0], wq_reg[rwp_pkg::DIV_Q_W-1]};
            wq_next  = {wq_reg[rwp_pkg::DIV_Q_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rwp_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = {{(rwp_pkg::RES_W-rwp_pkg::DIV_Q_W){1'b0}}, wq_next};
            end
        end
        else if (req.go)
        begin
            if (req.op == rwp_pkg::OP_DIV)
            begin
                busy_next = 1'b1;
                cnt_next  = rwp_pkg::DIV_CNT_W'(rwp_pkg::DIV_Q_W);
                rem_next  = {{(rwp_pkg::OPB_W-(rwp_pkg::OPA_W-rwp_pkg::DIV_Q_W)){1'b0}},
                             req.opa[rwp_pkg::OPA_W-1:rwp_pkg::DIV_Q_W]};
                wq_next   = req.opa[rwp_pkg::DIV_Q_W-1:0];
                dvs_next  = req.opb;
            end
            else
            begin
                done_next = 1'b1;
                res_next  = mul_prod;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        wq_reg  <= wq_next;
        dvs_reg <= dvs_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

    a_go_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.go |-> !busy_reg && !done_reg)
        else $error("arith unit started while busy");

    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (req.go && req.op == rwp_pkg::OP_DIV) |->
        (req.opa[rwp_pkg::OPA_W-1:rwp_pkg::DIV_Q_W] < req.opb))
        else $error("quotient does not fit the divider");

endmodule

@@ hw/rtl/rwp_core.sv @@
module rwp_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  rwp_pkg::cfg_t    cfg_regs,
    input  logic             in_valid,
    output logic             in_ready,
    input  rwp_pkg::item_t   item,
    output logic             res_valid,
    input  logic             res_ready,
    output rwp_pkg::result_t res
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SC   = 4'd1;
    localparam logic [3:0] S_SP   = 4'd2;
    localparam logic [3:0] S_M1   = 4'd3;
    localparam logic [3:0] S_M2   = 4'd4;
    localparam logic [3:0] S_M3   = 4'd5;
    localparam logic [3:0] S_D1   = 4'd6;
    localparam logic [3:0] S_M4   = 4'd7;
    localparam logic [3:0] S_M5   = 4'd8;
    localparam logic [3:0] S_D2   = 4'd9;
    localparam logic [3:0] S_M6   = 4'd10;
    localparam logic [3:0] S_WIN  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0]                     step_reg, step_next;
    logic                           pend_reg, pend_next;
    logic [rwp_pkg::FIELD_W-1:0]    now_reg, now_next;
    logic [rwp_pkg::FIELD_W-1:0]    prev_reg, prev_next;
    logic [rwp_pkg::FIELD_W-1:0]    cmd_reg, cmd_next;
    logic [rwp_pkg::SCALED_W-1:0]   c_reg, c_next;
    logic [rwp_pkg::SCALED_W-1:0]   p_reg, p_next;
    logic [rwp_pkg::SCALED_W-1:0]   a_reg, a_next;
    logic [rwp_pkg::SUM_W-1:0]      s_reg, s_next;
    logic [rwp_pkg::PROD_W-1:0]     m1_reg, m1_next;
    logic [rwp_pkg::PROD_W-1:0]     v_reg, v_next;
    logic [rwp_pkg::X_W-1:0]        x_reg, x_next;
    logic [rwp_pkg::RES_W-1:0]      work_reg, work_next;
    logic [rwp_pkg::PRED_W-1:0]     pred_reg, pred_next;
    logic [rwp_pkg::FIELD_W-1:0]    last_window_reg, last_window_next;
    rwp_pkg::result_t               res_reg, res_next;

    rwp_pkg::arith_req_t            req;
    rwp_pkg::arith_rsp_t            rsp;

    logic [rwp_pkg::SCALED_W-1:0]   scaled_q;
    logic [rwp_pkg::DIV_Q_W-3:0]    quarter_q;
    logic                           first_win;
    logic [rwp_pkg::FIELD_W-1:0]    window;
    logic [rwp_pkg::FIELD_W-1:0]    reduced;
    logic                           pulse_ok;

    rwp_arith u_arith
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign scaled_q  = rsp.res[rwp_pkg::SCALE_SHIFT +: rwp_pkg::SCALED_W];
    assign quarter_q = rsp.res[rwp_pkg::DIV_Q_W-1:2];
    assign first_win = (last_window_reg == '0);
    assign window    = rsp.res[rwp_pkg::WIN_SHIFT +: rwp_pkg::FIELD_W];
    assign reduced   = (window > rwp_pkg::GUARD_US) ? window - rwp_pkg::GUARD_US : '0;
    assign pulse_ok  = (reduced > cfg_regs.min_window) && (cmd_reg > cfg_regs.min_pulse);

    always_comb
    begin
        step_next        = step_reg;
        pend_next        = pend_reg;
        now_next         = now_reg;
        prev_next        = prev_reg;
        cmd_next         = cmd_reg;
        c_next           = c_reg;
        p_next           = p_reg;
        a_next           = a_reg;
        s_next           = s_reg;
        m1_next          = m1_reg;
        v_next           = v_reg;
        x_next           = x_reg;
        work_next        = work_reg;
        pred_next        = pred_reg;
        last_window_next = last_window_reg;
        res_next         = res_reg;
        req              = '0;

        // issue once per compute step, advance on done
        if (step_reg != S_IDLE && step_reg != S_DONE)
        begin
            req.go = !pend_reg;
            if (!pend_reg)
                pend_next = 1'b1;
            else if (rsp.done)
                pend_next = 1'b0;
        end

        case (step_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    now_next  = item.current_interval;
                    prev_next = item.previous_interval;
                    cmd_next  = item.on_time_command;
                    if (item.previous_interval == '0)
                    begin
                        res_next.rearm_delay  = cfg_regs.bounce_wait;
                        res_next.drive_time   = '0;
                        res_next.drive_enable = 1'b0;
                        step_next             = S_DONE;
                    end
                    else
                        step_next = S_SC;
                end
            end
            S_SC:
            begin
                req.op  = rwp_pkg::OP_MUL;
                req.opa = rwp_pkg::OPA_W'(now_reg);
                req.opb = rwp_pkg::OPB_W'(rwp_pkg::SCALE_RECIP);
                if (rsp.done)
                begin
                    c_next    = scaled_q;
                    step_next = S_SP;
                end
            end
            S_SP:
            begin
                req.op  = rwp_pkg::OP_MUL;
                req.opa = rwp_pkg::OPA_W'(prev_reg);
                req.opb = rwp_pkg::OPB_W'(rwp_pkg::SCALE_RECIP);
                if (rsp.done)
                begin
                    p_next = scaled_q;
                    a_next = scaled_q - c_reg;
                    s_next = {1'b0, scaled_q} + {1'b0, c_reg};
                    // speeding up only when the scaled prior exceeds the scaled latest
                    if (scaled_q > c_reg)
                        step_next = S_M1;
                    else
                    begin
                        pred_next = rwp_pkg::PRED_W'(now_reg);
                        step_next = S_WIN;
                    end
                end
            end
            S_M1:
            begin
                req.op  = rwp_pkg::OP_MUL;
                req.opa = rwp_pkg::OPA_W'(p_reg);
                req.opb = rwp_pkg::OPB_W'(c_reg);
                if (rsp.done)
                begin
                    m1_next   = rsp.res[rwp_pkg::PROD_W-1:0];
                    step_next = S_M2;
                end
            end
            S_M2:
            begin
                // v = (p-c)(p+c) + 2pc
                req.op  = rwp_pkg::OP_MUL;
                req.opa = rwp_pkg::OPA_W'(a_reg);
                req.opb = rwp_pkg::OPB_W'(s_reg);
                if (rsp.done)
                begin
                    v_next    = rsp.res[rwp_pkg::PROD_W-1:0] + {m1_reg[rwp_pkg::PROD_W-2:0], 1'b0};
                    step_next = S_M3;
                end
            end
            S_M3:
            begin
                // d = pc(p+c)
                req.op  = rwp_pkg::OP_MUL;
                req.opa = rwp_pkg::OPA_W'(m1_reg);
                req.opb = rwp_pkg::OPB_W'(s_reg);
                if (rsp.done)
                begin
                    work_next = rsp.res;
                    step_next = S_D1;
                end
            end
            S_D1:
            begin
                req.op  = rwp_pkg::OP_DIV;
                req.opa = work_reg[rwp_pkg::OPA_W-1:0];
                req.opb = v_reg;
                if (rsp.done)
                begin
                    x_next    = rsp.res[rwp_pkg::X_W-1:0];
                    step_next = S_M4;
                end
            end
            S_M4:
            begin
                req.op  = rwp_pkg::OP_MUL;
                req.opa = rwp_pkg::OPA_W'(x_reg);
                req.opb = rwp_pkg::OPB_W'(x_reg);
                if (rsp.done)
                begin
                    work_next = rsp.res;
                    step_next = S_M5;
                end
            end
            S_M5:
            begin
                req.op  = rwp_pkg::OP_MUL;
                req.opa = work_reg[rwp_pkg::OPA_W-1:0];
                req.opb = rwp_pkg::OPB_W'(a_reg);
                if (rsp.done)
                begin
                    work_next = rsp.res;
                    step_next = S_D2;
                end
            end
            S_D2:
            begin
                // x - x*x*a / v / 4
                req.op  = rwp_pkg::OP_DIV;
                req.opa = work_reg[rwp_pkg::OPA_W-1:0];
                req.opb = v_reg;
                if (rsp.done)
                begin
                    x_next    = x_reg - quarter_q[rwp_pkg::X_W-1:0];
                    step_next = S_M6;
                end
            end
            S_M6:
            begin
                req.op  = rwp_pkg::OP_MUL;
                req.opa = rwp_pkg::OPA_W'(x_reg);
                req.opb = rwp_pkg::SCALE_DIV;
                if (rsp.done)
                begin
                    pred_next = rsp.res[rwp_pkg::PRED_W-1:0];
                    step_next = S_WIN;
                end
            end
            S_WIN:
            begin
                // 4/5 on the first window, 6/7 after that
                req.op  = rwp_pkg::OP_MUL;
                req.opa = first_win ? rwp_pkg::WIN_RECIP_FIRST : rwp_pkg::WIN_RECIP_LATER;
                req.opb = rwp_pkg::OPB_W'(pred_reg);
                if (rsp.done)
                begin
                    last_window_next      = window;
                    res_next.rearm_delay  = window;
                    res_next.drive_time   = !pulse_ok ? '0
                                          : (cmd_reg < reduced) ? cmd_reg : reduced;
                    res_next.drive_enable = pulse_ok;
                    step_next             = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                    step_next = S_IDLE;
            end
            default:
            begin
                step_next = S_IDLE;
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= S_IDLE;
            pend_reg        <= 1'b0;
            last_window_reg <= '0;
        end
        else
        begin
            step_reg        <= step_next;
            pend_reg        <= pend_next;
            last_window_reg <= last_window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        prev_reg <= prev_next;
        cmd_reg  <= cmd_next;
        c_reg    <= c_next;
        p_reg    <= p_next;
        a_reg    <= a_next;
        s_reg    <= s_next;
        m1_reg   <= m1_next;
        v_reg    <= v_next;
        x_reg    <= x_next;
        work_reg <= work_next;
        pred_reg <= pred_next;
        res_reg  <= res_next;
    end

    assign in_ready  = (step_reg == S_IDLE);
    assign res_valid = (step_reg == S_DONE);
    assign res       = res_reg;

    a_done_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> pend_reg)
        else $error("arith result with no request outstanding");

    a_correction_le_x: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == S_D2 && rsp.done) |-> (quarter_q <= (rwp_pkg::DIV_Q_W-2)'(x_reg)))
        else $error("deceleration correction exceeds x");

endmodule
